@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the mapper RTL.
// Expects signals named clk and rst (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define SLBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slbm assertion failed");

// Next-cycle implication, held off during reset
`define SLBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slbm assertion failed");

`endif

@@ hw/rtl/slbm_pkg.sv @@
// Shared widths, constants and bank register type for the serial loaded bank mapper.
// No dependencies.
package slbm_pkg;

  localparam int ADDR_W = 16;
  localparam int DATA_W = 8;
  localparam int MAP_W  = 18;
  localparam int REG_W  = 5;
  localparam int CNT_W  = 3;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Reset values
  localparam logic [REG_W-1:0] CTRL_RESET       = 5'h0C;
  localparam logic [REG_W-1:0] BANK_COUNT_RESET = 5'd8;
  localparam logic [REG_W-1:0] CTRL_MODE_FORCE  = 5'h0C;

  // Serial loader completes after this many bits
  localparam logic [CNT_W-1:0] LOAD_BITS = 3'd5;

  // Bus address boundaries
  localparam logic [ADDR_W-1:0] CHR_END  = 16'h2000;
  localparam logic [ADDR_W-1:0] NT_END   = 16'h3F00;
  localparam logic [ADDR_W-1:0] RAM_BASE = 16'h6000;

  // Register target of a completed load, from address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LO  = 2'd1;
  localparam logic [1:0] SEL_CHR_HI  = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // Nametable mirroring modes, control bits 1:0
  localparam logic [1:0] NT_ONE_LO = 2'd0;
  localparam logic [1:0] NT_ONE_HI = 2'd1;
  localparam logic [1:0] NT_VERT   = 2'd2;
  localparam logic [1:0] NT_HORIZ  = 2'd3;

  // Bank registers seen by the address mapper
  typedef struct packed {
    logic [REG_W-1:0] control;
    logic [REG_W-1:0] chr_lo;
    logic [REG_W-1:0] chr_hi;
    logic [REG_W-1:0] prg;
    logic [REG_W-1:0] bank_count;
  } bank_regs_t;

endpackage

@@ hw/rtl/slbm_addr_map.sv @@
// Bus address to physical offset translation for CHR, nametable, PRG RAM and PRG ROM.
// Depends on slbm_pkg.
module slbm_addr_map (
  input  logic [slbm_pkg::ADDR_W-1:0] bus_address,
  input  slbm_pkg::bank_regs_t        regs,
  output logic [slbm_pkg::MAP_W-1:0]  phys_offset
);
  import slbm_pkg::*;

  always_comb begin
    logic [11:0]      off;
    logic [REG_W-1:0] last;
    logic [1:0]       prg_mode;
    off      = bus_address[11:0];
    prg_mode = regs.control[3:2];
    // last bank saturates at zero for an empty cartridge
    last     = (regs.bank_count == '0) ? '0 : regs.bank_count - 5'd1;
    phys_offset = '0;
    priority if (bus_address < CHR_END) begin
      // CHR: 4K halves or one 8K bank
      if (regs.control[4]) begin
        if (!bus_address[12]) phys_offset = {1'b0, regs.chr_lo, bus_address[11:0]};
        else                  phys_offset = {1'b0, regs.chr_hi, bus_address[11:0]};
      end else begin
        phys_offset = {1'b0, regs.chr_lo[4:1], bus_address[12:0]};
      end
    end else if (bus_address < NT_END) begin
      // nametable mirroring
      unique case (regs.control[1:0])
        NT_ONE_LO: phys_offset = {8'b0, off[9:0]};
        NT_ONE_HI: phys_offset = {7'b0, 1'b1, off[9:0]};
        NT_VERT:   phys_offset = {7'b0, off[10], off[9:0]};
        NT_HORIZ:  phys_offset = {7'b0, off[11], off[9:0]};
        default:   phys_offset = '0;
      endcase
    end else if (bus_address < RAM_BASE) begin
      phys_offset = {2'b0, bus_address};
    end else if (!bus_address[15]) begin
      // PRG RAM window
      phys_offset = {5'b0, bus_address[12:0]};
    end else begin
      // PRG ROM: 32K mode ignores the low bank bit
      if (!prg_mode[1]) begin
        phys_offset = {regs.prg[3:1], bus_address[14:0]};
      end else if (!bus_address[14]) begin
        if (!prg_mode[0]) phys_offset = {3'b0, bus_address[14:0]};
        else              phys_offset = {regs.prg[3:0], bus_address[13:0]};
      end else begin
        if (!prg_mode[0]) phys_offset = {regs.prg[3:0], bus_address[13:0]};
        else              phys_offset = {last[3:0], bus_address[13:0]};
      end
    end
  end

endmodule

@@ hw/rtl/serial_loaded_bank_mapper.sv @@
// Serial loaded bank mapper: an accepted item is held in the input register, then the
// serial load update and address map write its result into the result register.
// Throughput one item per cycle unless the output stalls; a stall blocks input only when both stages are full.
// Synchronous active-high reset empties both stages, clears the loader and banks,
// sets control to fixed-last-bank mode and the bank count to 8.
// Depends on slbm_pkg, slbm_addr_map and assert_macros.svh.
`include "assert_macros.svh"

module serial_loaded_bank_mapper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [slbm_pkg::ADDR_W-1:0] bus_address,
  input  logic [slbm_pkg::DATA_W-1:0] write_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slbm_pkg::MAP_W-1:0]  phys_offset,
  input  logic                        cfg_write,
  input  logic [slbm_pkg::REG_W-1:0]  cfg_data
);
  import slbm_pkg::*;

  // input stage
  logic              s1_valid;
  logic              s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_byte;

  // mapper state
  logic [REG_W-1:0] load_shift, load_shift_next;
  logic [CNT_W-1:0] load_count, load_count_next;
  bank_regs_t       banks, banks_next;

  logic             advance;
  logic [MAP_W-1:0] map_next;

  // stage 1 moves on when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_addr <= bus_address;
      s1_byte <= write_byte;
    end
  end

  // serial loader and register writes
  always_comb begin
    logic [CNT_W-1:0] count_inc;
    logic [REG_W-1:0] shift_in;
    count_inc       = load_count + 3'd1;
    shift_in        = {s1_byte[0], load_shift[REG_W-1:1]};
    load_shift_next = load_shift;
    load_count_next = load_count;
    banks_next      = banks;
    if (s1_op == OP_WRITE && s1_addr[15]) begin
      if (s1_byte[7]) begin
        // loader reset, forces fixed-last-bank mode
        load_shift_next    = '0;
        load_count_next    = '0;
        banks_next.control = banks.control | CTRL_MODE_FORCE;
      end else if (count_inc >= LOAD_BITS) begin
        unique case (s1_addr[14:13])
          SEL_CONTROL: banks_next.control = shift_in;
          SEL_CHR_LO:  banks_next.chr_lo  = shift_in;
          SEL_CHR_HI:  banks_next.chr_hi  = shift_in;
          SEL_PRG:     banks_next.prg     = shift_in;
          default:     banks_next.prg     = shift_in;
        endcase
        load_shift_next = '0;
        load_count_next = '0;
      end else begin
        load_shift_next = shift_in;
        load_count_next = count_inc;
      end
    end
  end

  // map with the state as it stands after this item's write
  slbm_addr_map u_map (
    .bus_address (s1_addr),
    .regs        (banks_next),
    .phys_offset (map_next)
  );

  // state registers; the bank count comes only from the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      load_shift       <= '0;
      load_count       <= '0;
      banks.control    <= CTRL_RESET;
      banks.chr_lo     <= '0;
      banks.chr_hi     <= '0;
      banks.prg        <= '0;
      banks.bank_count <= BANK_COUNT_RESET;
    end else begin
      if (advance) begin
        load_shift    <= load_shift_next;
        load_count    <= load_count_next;
        banks.control <= banks_next.control;
        banks.chr_lo  <= banks_next.chr_lo;
        banks.chr_hi  <= banks_next.chr_hi;
        banks.prg     <= banks_next.prg;
      end
      if (cfg_write) begin
        banks.bank_count <= cfg_data;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      phys_offset <= map_next;
    end
  end

  // checks
  `SLBM_ASSERT_IMP(a_stall_cause, !in_ready, s1_valid && out_valid && !out_ready)
  `SLBM_ASSERT_NXT(a_advance_result, advance, out_valid)
  `SLBM_ASSERT_NXT(a_loader_reset, advance && s1_op == OP_WRITE && s1_addr[15] && s1_byte[7], load_count == '0 && banks.control[3:2] == 2'b11)

endmodule
